FILE: rtl/tcw_pkg.sv
// tcw_pkg: shared types, codes and constants of the text console writer
// no dependencies; used by every module under rtl/
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 11;
    localparam int POS_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    localparam int TAB_STOP = 4;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_TAB,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: rtl/tcw_front.sv
// tcw_front: accepts items and classifies them into queue commands
// depends on tcw_pkg
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [tcw_pkg::KIND_W-1:0]  i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::ADDR_W-1:0]  i_cell_address,
    output logic                        o_push,
    output tcw_pkg::t_cmd               o_cmd
);

    localparam int CELL_COUNT = ROWS * COLUMNS;

    logic addr_in_range;

    assign o_push        = i_start && !i_busy;
    assign addr_in_range = (32'(i_cell_address) < CELL_COUNT);

    always_comb begin
        o_cmd.ch   = i_char_code;
        o_cmd.addr = i_cell_address;
        unique case (i_kind)
            tcw_pkg::KIND_CHAR: begin
                unique case (i_char_code)
                    tcw_pkg::CH_NEWLINE:   o_cmd.op = tcw_pkg::OP_NEWLINE;
                    tcw_pkg::CH_RETURN:    o_cmd.op = tcw_pkg::OP_RETURN;
                    tcw_pkg::CH_BACKSPACE: o_cmd.op = tcw_pkg::OP_BACKSPACE;
                    tcw_pkg::CH_TAB:       o_cmd.op = tcw_pkg::OP_TAB;
                    default:               o_cmd.op = tcw_pkg::OP_CHAR;
                endcase
            end
            tcw_pkg::KIND_CLEAR: o_cmd.op = tcw_pkg::OP_CLEAR;
            // reads past the store return zero, same as a no-op
            tcw_pkg::KIND_READ: o_cmd.op = addr_in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
            default: o_cmd.op = tcw_pkg::OP_NOP;
        endcase
    end

endmodule

FILE: rtl/tcw_cmd_queue.sv
// tcw_cmd_queue: short command queue between front and back
// depends on tcw_pkg
module tcw_cmd_queue #(
    parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tcw_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output tcw_pkg::t_cmd      o_cmd,
    output tcw_pkg::t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcw_pkg::t_cmd    r_slot [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_cmd          = r_slot[r_rptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count lost a push");

endmodule

FILE: rtl/tcw_back.sv
// tcw_back: cursor logic, cell memory and result register
// depends on tcw_pkg; fed by tcw_cmd_queue
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_attribute,
    input  tcw_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_pop,
    output logic                        o_init,
    output logic                        o_done,
    output logic [tcw_pkg::POS_W-1:0]   o_cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]  o_read_cell
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS + 1);
    localparam int PW = ($clog2(CELL_COUNT + 1) > tcw_pkg::POS_W) ?
                        $clog2(CELL_COUNT + 1) : tcw_pkg::POS_W;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_BLANK,
        S_TAB,
        S_SCROLL,
        S_SCROLL_LAST,
        S_SCROLL_BLANK,
        S_CLEAR,
        S_EMIT
    } t_state;

    t_state                       r_state;
    t_state                       r_ret;
    logic [RW-1:0]                r_row;
    logic [CW-1:0]                r_col;
    logic [CW-1:0]                r_stop;
    logic [AW-1:0]                r_idx;
    logic [AW-1:0]                r_wr_addr;
    logic                         r_wr_pend;
    logic [tcw_pkg::CHAR_W-1:0]   r_ch;
    logic                         r_is_read;
    logic [tcw_pkg::CELL_W-1:0]   r_rdata;
    logic [tcw_pkg::CELL_W-1:0]   r_mem [CELL_COUNT];

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
    logic [AW-1:0]                mem_raddr;

    logic [AW-1:0]                cur_idx;
    logic [PW-1:0]                pos_full;
    logic                         col_full;
    logic                         last_row;
    logic                         at_home;
    logic [CW-1:0]                col_eff;
    logic [CW:0]                  tab_base;
    logic [CW-1:0]                tab_stop;
    logic [CW-1:0]                col_inc;
    t_state                       print_state;
    logic [tcw_pkg::CELL_W-1:0]   blank_cell;

    assign o_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_init  = (r_state == S_INIT);

    assign cur_idx  = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign pos_full = PW'(r_row) * PW'(COLUMNS) + PW'(r_col);
    assign col_full = (r_col == CW'(COLUMNS));
    assign last_row = (r_row == RW'(ROWS - 1));
    assign at_home  = (r_row == '0) && (r_col == '0);
    assign col_inc  = r_col + CW'(1);

    // tab stop from the column the tab starts in, after a wrap if the row is full
    assign col_eff  = col_full ? '0 : r_col;
    assign tab_base = {1'b0, col_eff & ~CW'(tcw_pkg::TAB_STOP - 1)}
                      + (CW + 1)'(tcw_pkg::TAB_STOP);
    assign tab_stop = (tab_base > (CW + 1)'(COLUMNS)) ? CW'(COLUMNS) : tab_base[CW-1:0];

    assign print_state = (i_cmd.op == tcw_pkg::OP_CHAR) ? S_PUT : S_TAB;
    assign blank_cell  = {(r_state == S_INIT) ? tcw_pkg::ATTR_RESET : i_attribute,
                          tcw_pkg::BLANK_CHAR};

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_idx;
        mem_wdata = blank_cell;
        mem_raddr = r_idx;
        unique case (r_state)
            S_INIT, S_CLEAR, S_SCROLL_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_wdata = {i_attribute, r_ch};
            end
            S_BLANK, S_TAB: begin
                mem_we = 1'b1;
            end
            S_SCROLL: begin
                mem_we    = r_wr_pend;
                mem_waddr = r_wr_addr;
                mem_wdata = r_rdata;
            end
            S_SCROLL_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = r_wr_addr;
                mem_wdata = r_rdata;
            end
            S_IDLE: begin
                mem_raddr = AW'(i_cmd.addr);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_idx     <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_wr_pend <= 1'b0;
            o_done    <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_INIT, S_CLEAR: begin
                    if (r_idx == AW'(CELL_COUNT - 1)) begin
                        r_idx   <= '0;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_state <= (r_state == S_INIT) ? S_IDLE : S_EMIT;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_is_read <= (i_cmd.op == tcw_pkg::OP_READ);
                        r_ch      <= i_cmd.ch;
                        unique case (i_cmd.op)
                            tcw_pkg::OP_CHAR, tcw_pkg::OP_TAB: begin
                                r_stop <= tab_stop;
                                r_ret  <= print_state;
                                if (col_full) begin
                                    r_col <= '0;
                                    if (last_row) begin
                                        r_idx     <= AW'(COLUMNS);
                                        r_wr_pend <= 1'b0;
                                        r_state   <= S_SCROLL;
                                    end else begin
                                        r_row   <= r_row + RW'(1);
                                        r_state <= print_state;
                                    end
                                end else begin
                                    r_state <= print_state;
                                end
                            end
                            tcw_pkg::OP_NEWLINE: begin
                                r_col <= '0;
                                r_ret <= S_EMIT;
                                if (last_row) begin
                                    r_idx     <= AW'(COLUMNS);
                                    r_wr_pend <= 1'b0;
                                    r_state   <= S_SCROLL;
                                end else begin
                                    r_row   <= r_row + RW'(1);
                                    r_state <= S_EMIT;
                                end
                            end
                            tcw_pkg::OP_RETURN: begin
                                r_col   <= '0;
                                r_state <= S_EMIT;
                            end
                            tcw_pkg::OP_BACKSPACE: begin
                                if (at_home) begin
                                    r_state <= S_EMIT;
                                end else begin
                                    if (r_col == '0) begin
                                        r_row <= r_row - RW'(1);
                                        r_col <= CW'(COLUMNS - 1);
                                    end else begin
                                        r_col <= r_col - CW'(1);
                                    end
                                    r_state <= S_BLANK;
                                end
                            end
                            tcw_pkg::OP_CLEAR: begin
                                r_idx   <= '0;
                                r_state <= S_CLEAR;
                            end
                            default: begin
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_PUT: begin
                    r_col   <= col_inc;
                    r_state <= S_EMIT;
                end
                S_BLANK: begin
                    r_state <= S_EMIT;
                end
                S_TAB: begin
                    r_col <= col_inc;
                    if (col_inc == r_stop) begin
                        r_state <= S_EMIT;
                    end
                end
                S_SCROLL: begin
                    r_wr_addr <= r_idx - AW'(COLUMNS);
                    r_wr_pend <= 1'b1;
                    if (r_idx == AW'(CELL_COUNT - 1)) begin
                        r_state <= S_SCROLL_LAST;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_SCROLL_LAST: begin
                    r_idx   <= AW'(CELL_COUNT - COLUMNS);
                    r_state <= S_SCROLL_BLANK;
                end
                S_SCROLL_BLANK: begin
                    if (r_idx == AW'(CELL_COUNT - 1)) begin
                        r_state <= r_ret;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_EMIT: begin
                    o_done       <= 1'b1;
                    o_cursor_pos <= pos_full[tcw_pkg::POS_W-1:0];
                    o_read_cell  <= r_is_read ? r_rdata : '0;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(COLUMNS))
        else $error("cursor column past row end");

    a_done_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EMIT))
        else $error("result strobe without emit step");

    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.op == tcw_pkg::OP_READ) |=> (r_state == S_EMIT && r_is_read))
        else $error("read command did not go straight to emit");

endmodule

FILE: rtl/text_console_writer_unit.sv
// text_console_writer_unit: top level of the text console writer
// depends on tcw_pkg, tcw_front, tcw_cmd_queue, tcw_back
//
// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+-----------------------------------
// item      | in        | start high while busy low    | i_kind, i_char_code, i_cell_address
// result    | out       | o_done high for one cycle    | o_cursor_pos, o_read_cell
// config    | in        | psel & penable & pwrite      | paddr, pwdata (attribute at 0x0)
//
// back end: each step writes at most one cell through the single write port of the cell memory;
//   a tab blanks cells up to the next stop, a scroll moves every row up and blanks the last row,
//   and a clear blanks every cell
// reset: synchronous; afterwards busy stays high while the
//   cell memory is swept with blanks of attribute 0x07 (config writes still land)
// the item queue lets up to QUEUE_DEPTH items wait; busy rises when it is full
// the receiver cannot stall: each result transfer happens in its strobe cycle
module text_console_writer_unit #(
    parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS        = tcw_pkg::ROWS_DEF,
    parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // item channel
    input  logic                         start,
    output logic                         busy,
    input  logic [tcw_pkg::KIND_W-1:0]   i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::ADDR_W-1:0]   i_cell_address,

    // result channel
    output logic                         o_done,
    output logic [tcw_pkg::POS_W-1:0]    o_cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]   o_read_cell,

    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    // register index sits in the word address bit
    localparam logic REG_ATTRIBUTE = 1'b0;

    logic [tcw_pkg::ATTR_W-1:0] r_attribute;
    logic                       cfg_write;
    logic                       reg_index;

    logic                       push;
    tcw_pkg::t_cmd              front_cmd;
    tcw_pkg::t_cmd              queue_cmd;
    tcw_pkg::t_q_status         q_status;
    logic                       pop;
    logic                       back_init;

    // --- register port ---
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    // reads of an address past the register list return zero
    assign prdata = (reg_index == REG_ATTRIBUTE) ?
                    {{(tcw_pkg::PDATA_W - tcw_pkg::ATTR_W){1'b0}}, r_attribute} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attribute <= tcw_pkg::ATTR_RESET;
        end else if (cfg_write && reg_index == REG_ATTRIBUTE) begin
            r_attribute <= pwdata[tcw_pkg::ATTR_W-1:0];
        end
    end

    // hold items off while the queue is full or the power-up sweep runs
    assign busy = q_status.full || back_init;

    // --- front: accept and classify ---
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_start        (start),
        .i_busy         (busy),
        .i_kind         (i_kind),
        .i_char_code    (i_char_code),
        .i_cell_address (i_cell_address),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    // --- queue between the two halves ---
    tcw_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    // --- back: cursor, cell memory, result register ---
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_attribute  (r_attribute),
        .i_cmd        (queue_cmd),
        .i_cmd_valid  (!q_status.empty),
        .o_pop        (pop),
        .o_init       (back_init),
        .o_done       (o_done),
        .o_cursor_pos (o_cursor_pos),
        .o_read_cell  (o_read_cell)
    );

endmodule
